// ----- src/max_elevation_quadtree_defines.svh -----
// Assertion helpers shared by the RTL.
`ifndef MAX_ELEVATION_QUADTREE_DEFINES_SVH
`define MAX_ELEVATION_QUADTREE_DEFINES_SVH

// Same-cycle implication, gated off during reset.
`define MEQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated off during reset.
`define MEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/meq_pkg.sv -----
package meq_pkg;

    localparam int MAX_LEVELS_DEF = 8;
    localparam int ELEV_BITS_DEF  = 16;

    localparam int OP_W       = 2;
    localparam int IDX_W      = 9;
    localparam int LVL_W      = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_POST_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_POST_COLS = 1'b1;

    // Range flags from the node address unit.
    typedef struct packed {
        logic row_in;
        logic col_in;
    } t_dim_chk;

endpackage

// ----- src/meq_if.sv -----
interface meq_in_if import meq_pkg::*; #(
    parameter int ELEV_BITS = ELEV_BITS_DEF
) ();
    logic                        valid;
    logic                        ready;
    logic [OP_W-1:0]             operation;
    logic [IDX_W-1:0]            row_index;
    logic [IDX_W-1:0]            col_index;
    logic signed [ELEV_BITS-1:0] elevation;
    logic [LVL_W-1:0]            query_level;

    modport source (
        output valid, operation, row_index, col_index, elevation, query_level,
        input  ready
    );
    modport sink (
        input  valid, operation, row_index, col_index, elevation, query_level,
        output ready
    );
endinterface

interface meq_out_if import meq_pkg::*; #(
    parameter int ELEV_BITS = ELEV_BITS_DEF
) ();
    logic                        valid;
    logic                        ready;
    logic signed [ELEV_BITS-1:0] node_value;
    logic                        status;
    logic [LVL_W-1:0]            level_count;

    modport source (
        output valid, node_value, status, level_count,
        input  ready
    );
    modport sink (
        input  valid, node_value, status, level_count,
        output ready
    );
endinterface

// ----- src/meq_ram.sv -----
module meq_ram import meq_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int WIDTH = ELEV_BITS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/meq_node_addr.sv -----
module meq_node_addr import meq_pkg::*; #(
    parameter int MAX_LEVELS = MAX_LEVELS_DEF,
    localparam int CW        = MAX_LEVELS + 1,
    localparam int LW        = $clog2(MAX_LEVELS + 1),
    localparam int NAW       = 2 * MAX_LEVELS
) (
    input  logic           i_fold,   // 1: cell coords, 0: node coords
    input  logic [LW-1:0]  i_depth,
    input  logic [LW-1:0]  i_lvl,
    input  logic [CW-1:0]  i_row,
    input  logic [CW-1:0]  i_col,
    input  logic [CW-1:0]  i_rows,
    input  logic [CW-1:0]  i_cols,
    output logic [NAW-1:0] o_addr,
    output t_dim_chk       o_chk
);

    logic [LW-1:0]  s_up;
    logic [LW-1:0]  s_sel;
    logic [NAW-1:0] level_base;
    logic [NAW-1:0] row_part;
    logic [NAW-1:0] col_part;
    logic [CW:0]    rows_sum;
    logic [CW:0]    cols_sum;
    logic [CW:0]    rows_dim;
    logic [CW:0]    cols_dim;

    assign s_up  = i_depth - i_lvl;
    assign s_sel = i_fold ? s_up : '0;

    // (4^L-1)/3 = 0b0101..01 with L ones
    always_comb begin
        level_base = '0;
        for (int i = 0; i < MAX_LEVELS; i++) begin
            if (LW'(i) < i_lvl) begin
                level_base[2*i] = 1'b1;
            end
        end
    end

    assign row_part = NAW'(i_row >> s_sel) << i_lvl;
    assign col_part = NAW'(i_col >> s_sel);
    assign o_addr   = level_base + row_part + col_part;

    // nodes per axis: ceil((posts-1) / 2^(n-L))
    assign rows_sum = (CW+1)'(i_rows) + ((CW+1)'(1) << s_up) - (CW+1)'(2);
    assign cols_sum = (CW+1)'(i_cols) + ((CW+1)'(1) << s_up) - (CW+1)'(2);
    assign rows_dim = rows_sum >> s_up;
    assign cols_dim = cols_sum >> s_up;

    assign o_chk.row_in = (CW+1)'(i_row) < rows_dim;
    assign o_chk.col_in = (CW+1)'(i_col) < cols_dim;

endmodule

// ----- src/max_elevation_quadtree.sv -----
// Query steps: ST_QRD, ST_QDAT, ST_DONE. Write: post store, then for each valid cell
//   (up to 4 cells) one read-modify-write of the node store per tree level.
// Clear: one node-store word per cycle over all (4^MAX_LEVELS-1)/3 words (21845 at default).
// Throughput: one word at a time; ready only while idle, result held in an output register.
// Reset (sync, active low): node store swept to -2^(ELEV_BITS-1), 21845 words at default;
//   input not ready during the sweep, config writes taken in every state.
`include "max_elevation_quadtree_defines.svh"

module max_elevation_quadtree import meq_pkg::*; #(
    parameter int MAX_LEVELS = MAX_LEVELS_DEF,
    parameter int ELEV_BITS  = ELEV_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    meq_in_if.sink                i_in,
    meq_out_if.source             o_out
);

    localparam int CW         = MAX_LEVELS + 1;              // coordinate bits
    localparam int LW         = $clog2(MAX_LEVELS + 1);      // level bits
    localparam int NAW        = 2 * MAX_LEVELS;              // node address bits
    localparam int EW         = (CW > IDX_W) ? CW : IDX_W;   // compare width
    localparam int SIDE       = (1 << MAX_LEVELS) + 1;
    localparam int POST_DEPTH = SIDE * SIDE;
    localparam int PAW        = $clog2(POST_DEPTH);
    localparam int NODE_DEPTH = ((1 << (2 * MAX_LEVELS)) - 1) / 3;
    localparam int NODE_AW    = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;

    localparam logic [ELEV_BITS-1:0] EMPTY_VAL = {1'b1, {(ELEV_BITS-1){1'b0}}};

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_CLR   = 9'b000000010,
        ST_WPOST = 9'b000000100,
        ST_WCELL = 9'b000001000,
        ST_FRD   = 9'b000010000,
        ST_FWR   = 9'b000100000,
        ST_QRD   = 9'b001000000,
        ST_QDAT  = 9'b010000000,
        ST_DONE  = 9'b100000000
    } t_state;

    // ---------------- configuration ----------------
    logic [CW-1:0] r_rows, r_cols;
    logic [EW-1:0] cfg_ext;
    logic [CW-1:0] cfg_clamped;

    assign cfg_ext = EW'(i_cfg_data);

    always_comb begin
        if (cfg_ext < EW'(2)) begin
            cfg_clamped = CW'(2);
        end else if (cfg_ext > EW'(SIDE)) begin
            cfg_clamped = CW'(SIDE);
        end else begin
            cfg_clamped = cfg_ext[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= CW'(SIDE);
            r_cols <= CW'(SIDE);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_POST_ROWS: r_rows <= cfg_clamped;
                REG_POST_COLS: r_cols <= cfg_clamped;
                default: ;
            endcase
        end
    end

    // depth n: least k with 2^k >= max(rows,cols)-1
    logic [CW-1:0] span_m1;
    logic [LW-1:0] depth;

    assign span_m1 = ((r_rows > r_cols) ? r_rows : r_cols) - CW'(1);

    always_comb begin
        depth = LW'(MAX_LEVELS);
        for (int k = MAX_LEVELS - 1; k >= 0; k--) begin
            if ((CW'(1) << k) >= span_m1) begin
                depth = LW'(k);
            end
        end
    end

    // ---------------- sequencer state ----------------
    t_state                 r_state;
    logic [OP_W-1:0]        r_op;
    logic [CW-1:0]          r_row, r_col;
    logic                   r_row_fit, r_col_fit;   // index below 2^MAX_LEVELS+1
    logic [ELEV_BITS-1:0]   r_elev;
    logic [LVL_W-1:0]       r_qlvl;
    logic [1:0]             r_cell;                 // {row step, col step}
    logic [LW-1:0]          r_flvl;
    logic [NAW-1:0]         r_clr_addr;
    logic                   r_clr_reply;            // sweep came from a clear word
    logic                   r_q_post;               // query reads the post store
    logic [ELEV_BITS-1:0]   r_res_val;
    logic                   r_res_st;
    logic                   r_out_valid;
    logic [ELEV_BITS-1:0]   r_out_val;
    logic                   r_out_st;
    logic [LVL_W-1:0]       r_out_lvl;

    logic                   in_fire;
    logic [EW-1:0]          in_row_e, in_col_e;

    assign in_fire  = i_in.valid && i_in.ready;
    assign in_row_e = EW'(i_in.row_index);
    assign in_col_e = EW'(i_in.col_index);

    // fold cell of the current corner
    logic [CW-1:0] cell_a, cell_b;
    logic          cell_ok;
    logic          cell_last;
    logic          flvl_last;

    assign cell_a    = r_row - CW'(r_cell[1]);
    assign cell_b    = r_col - CW'(r_cell[0]);
    assign cell_ok   = (r_row >= CW'(r_cell[1])) && (r_col >= CW'(r_cell[0]))
                       && ((CW+1)'(cell_a) + (CW+1)'(1) < (CW+1)'(r_rows))
                       && ((CW+1)'(cell_b) + (CW+1)'(1) < (CW+1)'(r_cols))
                       && (depth != '0);
    assign cell_last = (r_cell == 2'b11);
    assign flvl_last = (r_flvl == depth - LW'(1));

    // post in grid
    logic post_in;
    assign post_in = r_row_fit && r_col_fit && (r_row < r_rows) && (r_col < r_cols);

    // ---------------- shared node address unit ----------------
    logic          fold_mode;
    logic [LW-1:0] au_lvl;
    logic [CW-1:0] au_row, au_col;
    logic [NAW-1:0] node_addr;
    t_dim_chk      dim_chk;

    assign fold_mode = (r_op == OP_WRITE);
    assign au_lvl    = fold_mode ? r_flvl : r_qlvl[LW-1:0];
    assign au_row    = fold_mode ? cell_a : r_row;
    assign au_col    = fold_mode ? cell_b : r_col;

    meq_node_addr #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_addr (
        .i_fold  (fold_mode),
        .i_depth (depth),
        .i_lvl   (au_lvl),
        .i_row   (au_row),
        .i_col   (au_col),
        .i_rows  (r_rows),
        .i_cols  (r_cols),
        .o_addr  (node_addr),
        .o_chk   (dim_chk)
    );

    // ---------------- stores ----------------
    logic                 node_we;
    logic [NAW-1:0]       node_waddr;
    logic [ELEV_BITS-1:0] node_wdata;
    logic [ELEV_BITS-1:0] node_rdata;
    logic                 fold_raise;

    // fold raises the node only when the post is higher
    assign fold_raise = $signed(r_elev) > $signed(node_rdata);
    assign node_we    = (r_state == ST_CLR) || ((r_state == ST_FWR) && fold_raise);
    assign node_waddr = (r_state == ST_CLR) ? r_clr_addr : node_addr;
    assign node_wdata = (r_state == ST_CLR) ? EMPTY_VAL : r_elev;

    meq_ram #(
        .DEPTH (NODE_DEPTH),
        .WIDTH (ELEV_BITS)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr[NODE_AW-1:0]),
        .i_wdata (node_wdata),
        .i_raddr (node_addr[NODE_AW-1:0]),
        .o_rdata (node_rdata)
    );

    logic                 post_we;
    logic [PAW-1:0]       post_addr;
    logic [ELEV_BITS-1:0] post_rdata;

    // row * (2^M + 1) + col
    assign post_addr = (PAW'(r_row) << MAX_LEVELS) + PAW'(r_row) + PAW'(r_col);
    assign post_we   = (r_state == ST_WPOST) && post_in;

    meq_ram #(
        .DEPTH (POST_DEPTH),
        .WIDTH (ELEV_BITS)
    ) u_post_ram (
        .i_clk   (i_clk),
        .i_we    (post_we),
        .i_waddr (post_addr),
        .i_wdata (r_elev),
        .i_raddr (post_addr),
        .o_rdata (post_rdata)
    );

    // ---------------- query decode ----------------
    logic [LVL_W-1:0] depth_e;
    logic             q_above, q_at_posts;
    logic             q_node_ok;

    assign depth_e    = LVL_W'(depth);
    assign q_above    = r_qlvl > depth_e;
    assign q_at_posts = r_qlvl == depth_e;
    assign q_node_ok  = r_row_fit && r_col_fit && dim_chk.row_in && dim_chk.col_in;

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_clr_addr  <= '0;
            r_clr_reply <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // the finish step reloads the output register itself
            if (o_out.ready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_op      <= i_in.operation;
                        r_row     <= in_row_e[CW-1:0];
                        r_col     <= in_col_e[CW-1:0];
                        r_row_fit <= in_row_e < EW'(SIDE);
                        r_col_fit <= in_col_e < EW'(SIDE);
                        r_elev    <= i_in.elevation;
                        r_qlvl    <= i_in.query_level;
                        r_cell    <= 2'b00;
                        r_res_val <= '0;
                        r_res_st  <= 1'b0;
                        case (i_in.operation)
                            OP_CLEAR: begin
                                r_clr_addr  <= '0;
                                r_clr_reply <= 1'b1;
                                r_state     <= ST_CLR;
                            end
                            OP_WRITE: r_state <= ST_WPOST;
                            OP_QUERY: r_state <= ST_QRD;
                            default: begin
                                r_res_st <= 1'b1;
                                r_state  <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_CLR: begin
                    r_clr_addr <= r_clr_addr + NAW'(1);
                    if (r_clr_addr == NAW'(NODE_DEPTH - 1)) begin
                        r_state <= r_clr_reply ? ST_DONE : ST_IDLE;
                    end
                end
                ST_WPOST: begin
                    if (post_in) begin
                        r_state <= ST_WCELL;
                    end else begin
                        r_res_st <= 1'b1;
                        r_state  <= ST_DONE;
                    end
                end
                ST_WCELL: begin
                    if (cell_ok) begin
                        r_flvl  <= '0;
                        r_state <= ST_FRD;
                    end else if (cell_last) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_cell <= r_cell + 2'd1;
                    end
                end
                ST_FRD: r_state <= ST_FWR;
                ST_FWR: begin
                    if (!flvl_last) begin
                        r_flvl  <= r_flvl + LW'(1);
                        r_state <= ST_FRD;
                    end else if (cell_last) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_cell  <= r_cell + 2'd1;
                        r_state <= ST_WCELL;
                    end
                end
                ST_QRD: begin
                    r_res_val <= EMPTY_VAL;
                    r_res_st  <= 1'b1;
                    r_q_post  <= q_at_posts;
                    if (q_above) begin
                        r_state <= ST_DONE;
                    end else if (q_at_posts) begin
                        r_state <= post_in ? ST_QDAT : ST_DONE;
                    end else begin
                        r_state <= q_node_ok ? ST_QDAT : ST_DONE;
                    end
                end
                ST_QDAT: begin
                    r_res_val <= r_q_post ? post_rdata : node_rdata;
                    r_res_st  <= 1'b0;
                    r_state   <= ST_DONE;
                end
                ST_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_val   <= r_res_val;
                        r_out_st    <= r_res_st;
                        r_out_lvl   <= depth_e;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.node_value  = r_out_val;
    assign o_out.status      = r_out_st;
    assign o_out.level_count = r_out_lvl;

    // ---------------- assertions ----------------
    `MEQ_ASSERT_SAME(a_node_we_src, node_we, (r_state == ST_CLR) || (r_state == ST_FWR),
        "node store written outside clear or fold")
    `MEQ_ASSERT_SAME(a_fold_raises, (r_state == ST_FWR) && node_we,
        $signed(r_elev) > $signed(node_rdata), "fold wrote a value that is not higher")
    `MEQ_ASSERT_NEXT(a_query_path, in_fire && (i_in.operation == OP_QUERY),
        r_state == ST_QRD, "query word did not enter the query read step")
    `MEQ_ASSERT_NEXT(a_done_loads, (r_state == ST_DONE) && !r_out_valid,
        r_out_valid && (r_state == ST_IDLE), "finished word not moved to output register")

endmodule
